// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge, off while reset is low.
`define CHK_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("check failed");

// Same, with a message of the caller's choice.
`define CHK_MSG(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// ===== hdl/cif_tok_pkg.sv =====
package cif_tok_pkg;

    localparam int CHAR_W     = 16;
    localparam int LINE_W     = 25;
    localparam int MAX_RES    = 3;
    localparam int PREFIX_LEN = 10;

    localparam logic [CHAR_W-1:0] CH_LF   = 16'h000A;
    localparam logic [CHAR_W-1:0] CH_CR   = 16'h000D;
    localparam logic [CHAR_W-1:0] CH_BOM  = 16'hFEFF;
    localparam logic [CHAR_W-1:0] CH_SEMI = 16'h003B;
    localparam logic [CHAR_W-1:0] CH_HASH = 16'h0023;
    localparam logic [CHAR_W-1:0] CH_SQ   = 16'h0027;
    localparam logic [CHAR_W-1:0] CH_DQ   = 16'h0022;

    localparam logic [3:0]        PREFIX_BOM_ONLY = 4'd15;
    localparam logic [LINE_W-1:0] LINE_MAX        = '1;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_COMMENT = 3'd1,
        MODE_BARE    = 3'd2,
        MODE_QUOTE   = 3'd3,
        MODE_HELD    = 3'd4,
        MODE_TEXT    = 3'd5,
        MODE_AFTER   = 3'd6
    } mode_t;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_CHAR  = 2'd1,
        KIND_END   = 2'd2,
        KIND_ERROR = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ERR_PREFIX     = 2'd0,
        ERR_OPEN_TEXT  = 2'd1,
        ERR_NO_SPACE   = 2'd2,
        ERR_OPEN_QUOTE = 2'd3
    } err_t;

    typedef struct packed {
        kind_t             kind;
        logic [CHAR_W-1:0] char_out;
        logic              was_quoted;
        logic [LINE_W-1:0] line_number;
        err_t              error_code;
        logic              run_last;
    } tok_res_t;

    // All results one character causes, packed for the output buffer.
    typedef struct packed {
        tok_res_t [MAX_RES-1:0] res;
        logic [1:0]             cnt;
    } step_out_t;

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        logic hit;
        hit = ((c >= 16'h0009) && (c <= 16'h000D)) ||
              (c == 16'h0020) || (c == 16'h0085) || (c == 16'h00A0) ||
              (c == 16'h1680) ||
              ((c >= 16'h2000) && (c <= 16'h200A)) ||
              (c == 16'h2028) || (c == 16'h2029) || (c == 16'h202F) ||
              (c == 16'h205F) || (c == 16'h3000);
        return hit;
    endfunction

    // "#\#CIF_2.0"
    function automatic logic [CHAR_W-1:0] magic_char(input logic [3:0] idx);
        logic [CHAR_W-1:0] ch;
        unique case (idx)
            4'd0:    ch = 16'h0023;
            4'd1:    ch = 16'h005C;
            4'd2:    ch = 16'h0023;
            4'd3:    ch = 16'h0043;
            4'd4:    ch = 16'h0049;
            4'd5:    ch = 16'h0046;
            4'd6:    ch = 16'h005F;
            4'd7:    ch = 16'h0032;
            4'd8:    ch = 16'h002E;
            4'd9:    ch = 16'h0030;
            default: ch = '0;
        endcase
        return ch;
    endfunction

    function automatic tok_res_t make_res(input kind_t k, input logic [CHAR_W-1:0] ch,
                                          input logic q, input logic [LINE_W-1:0] ln,
                                          input err_t e);
        tok_res_t r;
        r.kind        = k;
        r.char_out    = ch;
        r.was_quoted  = q;
        r.line_number = ln;
        r.error_code  = e;
        r.run_last    = 1'b0;
        return r;
    endfunction

endpackage

// ===== hdl/cif_tok_if.sv =====
interface cif_tok_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] char_code;
    logic        final_char;

    modport source (output valid, output char_code, output final_char, input ready);
    modport sink (input valid, input char_code, input final_char, output ready);
endinterface

interface cif_tok_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] char_out;
    logic        was_quoted;
    logic [24:0] line_number;
    logic [1:0]  error_code;
    logic        run_last;

    modport source (output valid, output kind, output char_out, output was_quoted,
                    output line_number, output error_code, output run_last, input ready);
    modport sink (input valid, input kind, input char_out, input was_quoted,
                  input line_number, input error_code, input run_last, output ready);
endinterface

// ===== hdl/cif_tok_core.sv =====
module cif_tok_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step_en,
    input  logic [15:0]                   char_code,
    input  logic                          final_char,
    output cif_tok_pkg::step_out_t        step_out
);
    import cif_tok_pkg::*;

    mode_t             mode_reg, mode_next;
    logic              qdbl_reg, qdbl_next;
    logic              pwn_reg, pwn_next;
    logic              cr_reg, cr_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic [LINE_W-1:0] tline_reg, tline_next;
    logic              tq_reg, tq_next;
    logic [3:0]        ppos_reg, ppos_next;
    logic              pm_reg, pm_next;
    logic              err_reg, err_next;

    tok_res_t [MAX_RES-1:0] res;
    logic [1:0]             n;
    logic [CHAR_W-1:0]      c;
    logic [CHAR_W-1:0]      qc;
    logic [3:0]             pidx;
    logic                   skip;
    logic                   latched;
    logic                   space;
    logic                   lf;

    always_comb
    begin
        mode_next  = mode_reg;
        qdbl_next  = qdbl_reg;
        pwn_next   = pwn_reg;
        cr_next    = cr_reg;
        line_next  = line_reg;
        tline_next = tline_reg;
        tq_next    = tq_reg;
        ppos_next  = ppos_reg;
        pm_next    = pm_reg;
        res        = '0;
        n          = '0;
        c          = char_code;
        qc         = qdbl_reg ? CH_DQ : CH_SQ;
        pidx       = '0;
        skip       = 1'b0;
        latched    = err_reg;
        space      = 1'b0;
        lf         = 1'b0;

        if (!err_reg)
        begin
            // CR -> LF, LF right after CR dropped
            if (c == CH_CR)
            begin
                c       = CH_LF;
                cr_next = 1'b1;
            end
            else if ((c == CH_LF) && cr_reg)
            begin
                cr_next = 1'b0;
                skip    = 1'b1;
            end
            else
            begin
                cr_next = 1'b0;
            end

            if (!skip && pm_reg && (ppos_reg == 4'd0) && (c == CH_BOM))
            begin
                ppos_next = PREFIX_BOM_ONLY;
                skip      = 1'b1;
            end

            if (!skip)
            begin
                space = is_space(c);
                lf    = (c == CH_LF);

                if (pm_reg)
                begin
                    pidx = (ppos_reg == PREFIX_BOM_ONLY) ? 4'd0 : ppos_reg;
                    if ((pidx < 4'(PREFIX_LEN)) && (c == magic_char(pidx)))
                    begin
                        ppos_next = pidx + 4'd1;
                        if (ppos_next == 4'(PREFIX_LEN))
                        begin
                            pm_next = 1'b0;
                            res[n]  = make_res(KIND_ERROR, '0, 1'b0, '0, ERR_PREFIX);
                            n       = n + 2'd1;
                            latched = 1'b1;
                        end
                    end
                    else
                    begin
                        pm_next = 1'b0;
                    end
                end

                if (!latched)
                begin
                    unique case (mode_reg)
                        MODE_COMMENT:
                        begin
                            if (lf)
                            begin
                                if (line_reg != LINE_MAX) line_next = line_reg + 1'b1;
                                mode_next = MODE_IDLE;
                            end
                        end
                        MODE_BARE:
                        begin
                            if (space)
                            begin
                                res[n] = make_res(KIND_END, '0, tq_next, tline_next, ERR_PREFIX);
                                n      = n + 2'd1;
                                if (lf && (line_reg != LINE_MAX)) line_next = line_reg + 1'b1;
                                mode_next = MODE_IDLE;
                            end
                            else
                            begin
                                res[n] = make_res(KIND_CHAR, c, tq_next, tline_next, ERR_PREFIX);
                                n      = n + 2'd1;
                            end
                        end
                        MODE_QUOTE:
                        begin
                            if (lf)
                            begin
                                res[n] = make_res(KIND_ERROR, '0, 1'b0, tline_next,
                                                  ERR_OPEN_QUOTE);
                                n       = n + 2'd1;
                                latched = 1'b1;
                            end
                            else if (c == qc)
                            begin
                                mode_next = MODE_HELD;
                            end
                            else
                            begin
                                res[n] = make_res(KIND_CHAR, c, tq_next, tline_next, ERR_PREFIX);
                                n      = n + 2'd1;
                            end
                        end
                        MODE_HELD:
                        begin
                            // held quote closes only before whitespace or at the end of the text
                            if (space)
                            begin
                                res[n] = make_res(KIND_END, '0, tq_next, tline_next, ERR_PREFIX);
                                n      = n + 2'd1;
                                if (lf && (line_reg != LINE_MAX)) line_next = line_reg + 1'b1;
                                mode_next = MODE_IDLE;
                            end
                            else
                            begin
                                res[n] = make_res(KIND_CHAR, qc, tq_next, tline_next, ERR_PREFIX);
                                n      = n + 2'd1;
                                if (c != qc)
                                begin
                                    res[n] = make_res(KIND_CHAR, c, tq_next, tline_next,
                                                      ERR_PREFIX);
                                    n         = n + 2'd1;
                                    mode_next = MODE_QUOTE;
                                end
                            end
                        end
                        MODE_TEXT:
                        begin
                            if ((c == CH_SEMI) && pwn_reg)
                            begin
                                res[n] = make_res(KIND_END, '0, tq_next, tline_next, ERR_PREFIX);
                                n         = n + 2'd1;
                                mode_next = MODE_AFTER;
                            end
                            else
                            begin
                                res[n] = make_res(KIND_CHAR, c, tq_next, tline_next, ERR_PREFIX);
                                n      = n + 2'd1;
                                if (lf && (line_reg != LINE_MAX)) line_next = line_reg + 1'b1;
                            end
                        end
                        MODE_AFTER:
                        begin
                            if (space)
                            begin
                                if (lf && (line_reg != LINE_MAX)) line_next = line_reg + 1'b1;
                                mode_next = MODE_IDLE;
                            end
                            else
                            begin
                                res[n] = make_res(KIND_ERROR, '0, 1'b0, line_reg, ERR_NO_SPACE);
                                n       = n + 2'd1;
                                latched = 1'b1;
                            end
                        end
                        default:
                        begin
                            // between tokens
                            if (space)
                            begin
                                if (lf && (line_reg != LINE_MAX)) line_next = line_reg + 1'b1;
                                mode_next = MODE_IDLE;
                            end
                            else if (c == CH_HASH)
                            begin
                                mode_next = MODE_COMMENT;
                            end
                            else if ((c == CH_SEMI) && pwn_reg)
                            begin
                                tline_next = line_reg;
                                tq_next    = 1'b1;
                                res[n] = make_res(KIND_START, '0, 1'b1, line_reg, ERR_PREFIX);
                                n         = n + 2'd1;
                                mode_next = MODE_TEXT;
                            end
                            else if ((c == CH_SQ) || (c == CH_DQ))
                            begin
                                tline_next = line_reg;
                                tq_next    = 1'b1;
                                res[n] = make_res(KIND_START, '0, 1'b1, line_reg, ERR_PREFIX);
                                n         = n + 2'd1;
                                qdbl_next = (c == CH_DQ);
                                mode_next = MODE_QUOTE;
                            end
                            else
                            begin
                                tline_next = line_reg;
                                tq_next    = 1'b0;
                                res[n] = make_res(KIND_START, '0, 1'b0, line_reg, ERR_PREFIX);
                                n      = n + 2'd1;
                                res[n] = make_res(KIND_CHAR, c, 1'b0, line_reg, ERR_PREFIX);
                                n         = n + 2'd1;
                                mode_next = MODE_BARE;
                            end
                        end
                    endcase
                end

                pwn_next = lf;
            end

            // close out the text
            if (final_char && !latched)
            begin
                unique case (mode_next)
                    MODE_BARE, MODE_HELD:
                    begin
                        res[n] = make_res(KIND_END, '0, tq_next, tline_next, ERR_PREFIX);
                        n      = n + 2'd1;
                    end
                    MODE_QUOTE:
                    begin
                        res[n] = make_res(KIND_ERROR, '0, 1'b0, tline_next, ERR_OPEN_QUOTE);
                        n       = n + 2'd1;
                        latched = 1'b1;
                    end
                    MODE_TEXT:
                    begin
                        res[n] = make_res(KIND_ERROR, '0, 1'b0, tline_next, ERR_OPEN_TEXT);
                        n       = n + 2'd1;
                        latched = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        err_next = latched;

        if (final_char)
        begin
            mode_next  = MODE_IDLE;
            qdbl_next  = 1'b0;
            pwn_next   = 1'b1;
            cr_next    = 1'b0;
            line_next  = LINE_W'(1);
            tline_next = '0;
            tq_next    = 1'b0;
            ppos_next  = '0;
            pm_next    = 1'b1;
            err_next   = 1'b0;
        end

        if (n != 2'd0) res[n - 2'd1].run_last = 1'b1;

        step_out.res = res;
        step_out.cnt = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            qdbl_reg  <= 1'b0;
            pwn_reg   <= 1'b1;
            cr_reg    <= 1'b0;
            line_reg  <= LINE_W'(1);
            tline_reg <= '0;
            tq_reg    <= 1'b0;
            ppos_reg  <= '0;
            pm_reg    <= 1'b1;
            err_reg   <= 1'b0;
        end
        else if (step_en)
        begin
            mode_reg  <= mode_next;
            qdbl_reg  <= qdbl_next;
            pwn_reg   <= pwn_next;
            cr_reg    <= cr_next;
            line_reg  <= line_next;
            tline_reg <= tline_next;
            tq_reg    <= tq_next;
            ppos_reg  <= ppos_next;
            pm_reg    <= pm_next;
            err_reg   <= err_next;
        end
    end

endmodule

// ===== hdl/cif_tok_outbuf.sv =====
`include "assert_macros.svh"

module cif_tok_outbuf (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  cif_tok_pkg::step_out_t bundle,
    output logic                   free,
    cif_tok_out_if.source          tokens
);
    import cif_tok_pkg::*;

    step_out_t  bundle_reg;
    logic       valid_reg;
    logic [1:0] idx_reg;
    logic [1:0] cnt_reg;
    tok_res_t   cur;
    logic       fire;

    always_comb
    begin
        unique case (idx_reg)
            2'd0:    cur = bundle_reg.res[0];
            2'd1:    cur = bundle_reg.res[1];
            default: cur = bundle_reg.res[2];
        endcase
    end

    assign fire = valid_reg && tokens.ready;
    // bundle can take new words this edge
    assign free = !valid_reg || (tokens.ready && cur.run_last);

    assign tokens.valid       = valid_reg;
    assign tokens.kind        = cur.kind;
    assign tokens.char_out    = cur.char_out;
    assign tokens.was_quoted  = cur.was_quoted;
    assign tokens.line_number = cur.line_number;
    assign tokens.error_code  = cur.error_code;
    assign tokens.run_last    = cur.run_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
            cnt_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
            cnt_reg   <= bundle.cnt;
        end
        else if (fire)
        begin
            if (cur.run_last)
            begin
                valid_reg <= 1'b0;
                cnt_reg   <= '0;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bundle_reg <= bundle;
        end
    end

    `CHK_MSG(a_idx_in_range, clk, rst_n, valid_reg |-> (idx_reg < cnt_reg), "word index past count")
    `CHK_ALWAYS(a_last_at_end, clk, rst_n, valid_reg |-> (cur.run_last == (idx_reg == (cnt_reg - 2'd1))))
    `CHK_ALWAYS(a_drain_ends, clk, rst_n, (fire && cur.run_last && !load) |=> !valid_reg)

endmodule

// ===== hdl/cif_text_tokenizer_unit.sv =====
// A character in the input register is decoded once the result register is free;
// its words then load into the result register (two registers: input, result).
// Throughput: one character per cycle while each yields at most one word and the
// output is ready; one with 2 or 3 words holds the result register till all are out.
// Reset (rst_n low, asynchronous): scanner returns to start-of-text, line 1,
// input and result registers empty.
module cif_text_tokenizer_unit (
    input  logic          clk,
    input  logic          rst_n,
    cif_tok_in_if.sink    chars,
    cif_tok_out_if.source tokens
);
    import cif_tok_pkg::*;

    // Input register: holds one character, so the upstream side can hand over
    // one more while a word waits on the output.
    logic              in_valid_reg;
    logic [CHAR_W-1:0] char_reg;
    logic              fin_reg;

    logic      step_en;
    logic      buf_free;
    logic      load;
    step_out_t step_out;

    // The scanner advances when the result register can take everything
    // this character produces. Characters with no output (whitespace,
    // comments, dropped LF or BOM) still wait for that slot, which keeps
    // word order simple.
    assign step_en = in_valid_reg && buf_free;
    assign load    = step_en && (step_out.cnt != 2'd0);

    // Input slot frees when its character is decoded this cycle.
    assign chars.ready = !in_valid_reg || step_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (chars.ready)
        begin
            in_valid_reg <= chars.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            char_reg <= chars.char_code;
            fin_reg  <= chars.final_char;
        end
    end

    // Mode logic, line counter, CR/LF folding, prefix match, error latch.
    cif_tok_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (step_en),
        .char_code  (char_reg),
        .final_char (fin_reg),
        .step_out   (step_out)
    );

    // Holds up to three words of one character and hands them out in order.
    cif_tok_outbuf u_outbuf (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load),
        .bundle (step_out),
        .free   (buf_free),
        .tokens (tokens)
    );

endmodule
